// ===== rtl/rmd_pkg.sv =====
// Package for the ROI motion detector: widths, register indexes, the
// evaluator's state codes and the result struct. No dependencies.
package rmd_pkg;

  localparam int PIX_W    = 8;
  localparam int COORD_W  = 12;
  localparam int DIM_W    = 13;
  localparam int DEV_W    = 8;
  localparam int COVER_W  = 9;
  localparam int VSUM_W   = 32;
  localparam int SQSUM_W  = 40;
  localparam int COUNT_W  = 25;
  localparam int AREA_W   = 2 * DIM_W;
  localparam int AA_W     = 2 * AREA_W;
  localparam int D2_W     = 2 * DEV_W;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 69;
  localparam int THR_W    = COVER_W + AREA_W - 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [PIX_W-1:0] PIX_CHANGED = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROI_X      = 3'd0,
    CFG_ROI_Y      = 3'd1,
    CFG_ROI_WIDTH  = 3'd2,
    CFG_ROI_HEIGHT = 3'd3,
    CFG_MAX_DEV    = 3'd4,
    CFG_COVER      = 3'd5
  } cfg_idx_t;

  typedef enum logic [10:0] {
    E_IDLE = 11'b000_0000_0001,
    E_AREA = 11'b000_0000_0010,
    E_A_LO = 11'b000_0000_0100,
    E_A_HI = 11'b000_0000_1000,
    E_AA   = 11'b000_0001_0000,
    E_D2   = 11'b000_0010_0000,
    E_B_LO = 11'b000_0100_0000,
    E_B_HI = 11'b000_1000_0000,
    E_S2   = 11'b001_0000_0000,
    E_CMP  = 11'b010_0000_0000,
    E_HOLD = 11'b100_0000_0000
  } eval_state_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             noisy;
    logic [THR_W-1:0] thr;
  } eval_res_t;

endpackage

// ===== rtl/rmd_pix_if.sv =====
// Pixel channel: valid/ready handshake with one pixel and its coordinates.
// Depends on rmd_pkg.
interface rmd_pix_if;
  import rmd_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_value;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic               frame_last;

  modport source (output valid, pixel_value, pixel_x, pixel_y, frame_last, input ready);
  modport sink   (input valid, pixel_value, pixel_x, pixel_y, frame_last, output ready);
endinterface

// ===== rtl/rmd_res_if.sv =====
// Result channel: valid/ready handshake carrying one per-frame verdict.
// Depends on rmd_pkg.
interface rmd_res_if;
  import rmd_pkg::*;

  logic               valid;
  logic               ready;
  logic               motion_found;
  logic               too_noisy;
  logic [COUNT_W-1:0] changed_count;

  modport source (output valid, motion_found, too_noisy, changed_count, input ready);
  modport sink   (input valid, motion_found, too_noisy, changed_count, output ready);
endinterface

// ===== rtl/rmd_eval.sv =====
// End-of-frame evaluator: a small sequencer around one shared 32x32
// multiplier builds N*sumsq and sum^2 + D^2*N^2, compares them and forms the
// cover threshold. Depends on rmd_pkg.
module rmd_eval (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       out_free,
  input  logic [rmd_pkg::DIM_W-1:0]   roi_w,
  input  logic [rmd_pkg::DIM_W-1:0]   roi_h,
  input  logic [rmd_pkg::DEV_W-1:0]   max_dev,
  input  logic [rmd_pkg::COVER_W-1:0] cover_ratio,
  input  logic [rmd_pkg::VSUM_W-1:0]  vsum,
  input  logic [rmd_pkg::SQSUM_W-1:0] sqsum,
  output rmd_pkg::eval_res_t          res
);
  import rmd_pkg::*;

  eval_state_t        state_r, state_nxt;
  logic [AREA_W-1:0]  area_r;
  logic [AA_W-1:0]    aa_r;
  logic [D2_W-1:0]    d2_r;
  logic [ACC_W-1:0]   a_r;
  logic [ACC_W-1:0]   acc_r;
  logic               noisy_r;
  logic [THR_W-1:0]   thr_r;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   prod_ext;
  logic [ACC_W-1:0]   prod_hi;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      E_AREA: begin
        mul_a = MUL_W'(roi_w);
        mul_b = MUL_W'(roi_h);
      end
      E_A_LO: begin
        mul_a = MUL_W'(area_r);
        mul_b = sqsum[MUL_W-1:0];
      end
      E_A_HI: begin
        mul_a = MUL_W'(area_r);
        mul_b = MUL_W'(sqsum[SQSUM_W-1:MUL_W]);
      end
      E_AA: begin
        mul_a = MUL_W'(area_r);
        mul_b = MUL_W'(area_r);
      end
      E_D2: begin
        mul_a = MUL_W'(max_dev);
        mul_b = MUL_W'(max_dev);
      end
      E_B_LO: begin
        mul_a = MUL_W'(d2_r);
        mul_b = aa_r[MUL_W-1:0];
      end
      E_B_HI: begin
        mul_a = MUL_W'(d2_r);
        mul_b = MUL_W'(aa_r[AA_W-1:MUL_W]);
      end
      E_S2: begin
        mul_a = vsum;
        mul_b = vsum;
      end
      E_CMP: begin
        mul_a = MUL_W'(cover_ratio);
        mul_b = MUL_W'(area_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_ext = ACC_W'(prod);
  assign prod_hi  = prod_ext << MUL_W;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      E_IDLE:  if (start) state_nxt = E_AREA;
      E_AREA:  state_nxt = E_A_LO;
      E_A_LO:  state_nxt = E_A_HI;
      E_A_HI:  state_nxt = E_AA;
      E_AA:    state_nxt = E_D2;
      E_D2:    state_nxt = E_B_LO;
      E_B_LO:  state_nxt = E_B_HI;
      E_B_HI:  state_nxt = E_S2;
      E_S2:    state_nxt = E_CMP;
      E_CMP:   state_nxt = E_HOLD;
      E_HOLD:  if (out_free) state_nxt = E_IDLE;
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      E_AREA: area_r  <= prod[AREA_W-1:0];
      E_A_LO: acc_r   <= prod_ext;
      E_A_HI: a_r     <= acc_r + prod_hi;
      E_AA:   aa_r    <= prod[AA_W-1:0];
      E_D2:   d2_r    <= prod[D2_W-1:0];
      E_B_LO: acc_r   <= prod_ext;
      E_B_HI: acc_r   <= acc_r + prod_hi;
      E_S2:   acc_r   <= acc_r + prod_ext;
      E_CMP: begin
        noisy_r <= a_r > acc_r;
        thr_r   <= prod[THR_W+7:8];
      end
      default: begin
      end
    endcase
  end

  assign res.busy  = state_r != E_IDLE;
  assign res.done  = state_r == E_HOLD;
  assign res.noisy = noisy_r;
  assign res.thr   = thr_r;

endmodule

// ===== rtl/roi_motion_detector.sv =====
// ROI motion detector top level: configuration registers, rectangle test,
// accumulators and result register. Depends on rmd_pkg, rmd_pix_if,
// rmd_res_if and rmd_eval.
//
// Pixels are taken one per cycle with in_pix.ready high; those inside the
// watched rectangle add to a sum, a sum of squares and a count of pixels at
// 255. The beat flagged frame_last is accumulated too, then ready drops
// while one shared 32x32 multiplier works through the deviation test and
// the cover threshold in nine steps; the result is then loaded into the
// output register and the accumulators clear. If the previous result is
// still waiting, the block holds until it is taken. Width and height are
// capped at MAX_DIM. Registers may be written only while no frame is open.
module roi_motion_detector #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rmd_pix_if.sink                       in_pix,
  rmd_res_if.source                     out_res,
  input  logic                          cfg_we,
  input  logic [rmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rmd_pkg::*;

  logic [COORD_W-1:0] roi_x_r, roi_y_r;
  logic [DIM_W-1:0]   roi_width_r, roi_height_r;
  logic [DEV_W-1:0]   max_dev_r;
  logic [COVER_W-1:0] cover_r;

  logic [VSUM_W-1:0]  vsum_r;
  logic [SQSUM_W-1:0] sqsum_r;
  logic [COUNT_W-1:0] count_r;

  logic               out_valid_r;
  logic               motion_r;
  logic               noisy_out_r;
  logic [COUNT_W-1:0] count_out_r;

  logic [DIM_W-1:0]   w_sat, h_sat;
  logic [DIM_W:0]     x_end, y_end;
  logic               in_roi;
  logic               in_acc;
  logic               out_free;
  logic               load;
  logic [2*PIX_W-1:0] pix_sq;
  eval_res_t          ev_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roi_x_r      <= '0;
      roi_y_r      <= '0;
      roi_width_r  <= 13'd64;
      roi_height_r <= 13'd64;
      max_dev_r    <= 8'd100;
      cover_r      <= 9'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROI_X:      roi_x_r      <= cfg_wdata[COORD_W-1:0];
        CFG_ROI_Y:      roi_y_r      <= cfg_wdata[COORD_W-1:0];
        CFG_ROI_WIDTH:  roi_width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_ROI_HEIGHT: roi_height_r <= cfg_wdata[DIM_W-1:0];
        CFG_MAX_DEV:    max_dev_r    <= cfg_wdata[DEV_W-1:0];
        CFG_COVER:      cover_r      <= cfg_wdata[COVER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Dimensions capped at MAX_DIM for both the inside test and the area.
  assign w_sat = ({1'b0, roi_width_r} > (DIM_W+1)'(MAX_DIM))  ? DIM_W'(MAX_DIM) : roi_width_r;
  assign h_sat = ({1'b0, roi_height_r} > (DIM_W+1)'(MAX_DIM)) ? DIM_W'(MAX_DIM) : roi_height_r;

  assign x_end  = (DIM_W+1)'(roi_x_r) + (DIM_W+1)'(w_sat);
  assign y_end  = (DIM_W+1)'(roi_y_r) + (DIM_W+1)'(h_sat);
  assign in_roi = (in_pix.pixel_x >= roi_x_r) && ((DIM_W+1)'(in_pix.pixel_x) < x_end) &&
                  (in_pix.pixel_y >= roi_y_r) && ((DIM_W+1)'(in_pix.pixel_y) < y_end);

  assign in_pix.ready = !ev_res.busy;
  assign in_acc       = in_pix.valid && in_pix.ready;
  assign pix_sq       = (2*PIX_W)'(in_pix.pixel_value) * (2*PIX_W)'(in_pix.pixel_value);

  assign out_free = !out_valid_r || out_res.ready;
  assign load     = ev_res.done && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsum_r  <= '0;
      sqsum_r <= '0;
      count_r <= '0;
    end else if (load) begin
      vsum_r  <= '0;
      sqsum_r <= '0;
      count_r <= '0;
    end else if (in_acc && in_roi) begin
      vsum_r  <= vsum_r + VSUM_W'(in_pix.pixel_value);
      sqsum_r <= sqsum_r + SQSUM_W'(pix_sq);
      if (in_pix.pixel_value == PIX_CHANGED) begin
        count_r <= count_r + COUNT_W'(1);
      end
    end
  end

  rmd_eval u_eval (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_acc && in_pix.frame_last),
    .out_free    (out_free),
    .roi_w       (w_sat),
    .roi_h       (h_sat),
    .max_dev     (max_dev_r),
    .cover_ratio (cover_r),
    .vsum        (vsum_r),
    .sqsum       (sqsum_r),
    .res         (ev_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      motion_r    <= !ev_res.noisy && ((THR_W+1)'(count_r) > (THR_W+1)'(ev_res.thr));
      noisy_out_r <= ev_res.noisy;
      count_out_r <= count_r;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.motion_found  = motion_r;
  assign out_res.too_noisy     = noisy_out_r;
  assign out_res.changed_count = count_out_r;

  a_res_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_res.valid) |-> $past(ev_res.done))
    else $error("result beat without finished evaluation");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (vsum_r == '0 && sqsum_r == '0 && count_r == '0))
    else $error("accumulators not cleared after result");

  a_motion_not_noisy: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> !(out_res.motion_found && out_res.too_noisy))
    else $error("motion reported on a noisy frame");

  a_no_beat_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_pix.frame_last) |=> !in_pix.ready)
    else $error("pixel channel open during evaluation");

endmodule

// ===== dv/rmd_verdict_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the ROI motion detector: follows register writes and pixel
// beats, predicts each per-frame verdict and compares it with the result
// channel. Depends on rmd_pkg, rmd_pix_if and rmd_res_if.
module rmd_verdict_checker #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rmd_pix_if                             pix,
  rmd_res_if                             res,
  input  logic                           cfg_we,
  input  logic [rmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             pending
);
  import rmd_pkg::*;

  typedef struct packed {
    logic               motion;
    logic               noisy;
    logic [COUNT_W-1:0] count;
  } verdict_t;

  verdict_t verdict_q[$];

  logic [COORD_W-1:0] roi_x, roi_y;
  logic [DIM_W-1:0]   roi_w, roi_h;
  logic [DEV_W-1:0]   max_dev;
  logic [COVER_W-1:0] cover_frac;
  logic [VSUM_W-1:0]  v_sum;
  logic [SQSUM_W-1:0] sq_sum;
  logic [COUNT_W-1:0] hits;

  function automatic int capped(input logic [DIM_W-1:0] d);
    return (d > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  // exact deviation test: N*sumsq > sum^2 + D^2*N^2
  function automatic verdict_t judge_frame();
    logic [47:0]  area;
    logic [127:0] spread, bound;
    logic [63:0]  cut;
    verdict_t     v;
    area   = 48'(capped(roi_w)) * 48'(capped(roi_h));
    spread = 128'(area) * 128'(sq_sum);
    bound  = 128'(max_dev) * 128'(max_dev) * 128'(area) * 128'(area)
           + 128'(v_sum) * 128'(v_sum);
    cut    = (64'(cover_frac) * 64'(area)) >> 8;
    v.noisy  = spread > bound;
    v.motion = !v.noisy && (64'(hits) > cut);
    v.count  = hits;
    return v;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t got, want;
    int       px, py;
    if (!rst_n) begin
      roi_x = '0; roi_y = '0; roi_w = 13'd64; roi_h = 13'd64;
      max_dev = 8'd100; cover_frac = 9'd64;
      v_sum = '0; sq_sum = '0; hits = '0;
      verdict_q.delete();
      mismatches = 0;
    end else begin
      if (res.valid && res.ready) begin
        got = '{res.motion_found, res.too_noisy, res.changed_count};
        if (verdict_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result motion %0b noisy %0b count %0d",
                     $realtime, got.motion, got.noisy, got.count);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (got != want) begin
            if (mismatches < 10)
              $display("%0t: motion %0b/%0b noisy %0b/%0b count %0d/%0d (exp/act)",
                       $realtime, want.motion, got.motion, want.noisy, got.noisy,
                       want.count, got.count);
            mismatches++;
          end
        end
      end
      if (pix.valid && pix.ready) begin
        px = int'(pix.pixel_x);
        py = int'(pix.pixel_y);
        if (px >= int'(roi_x) && px < int'(roi_x) + capped(roi_w) &&
            py >= int'(roi_y) && py < int'(roi_y) + capped(roi_h)) begin
          v_sum  = v_sum + VSUM_W'(pix.pixel_value);
          sq_sum = sq_sum + SQSUM_W'(pix.pixel_value) * SQSUM_W'(pix.pixel_value);
          if (pix.pixel_value == PIX_CHANGED)
            hits = hits + COUNT_W'(1);
        end
        if (pix.frame_last) begin
          verdict_q.push_back(judge_frame());
          v_sum = '0; sq_sum = '0; hits = '0;
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ROI_X:      roi_x = cfg_wdata[COORD_W-1:0];
          CFG_ROI_Y:      roi_y = cfg_wdata[COORD_W-1:0];
          CFG_ROI_WIDTH:  roi_w = cfg_wdata[DIM_W-1:0];
          CFG_ROI_HEIGHT: roi_h = cfg_wdata[DIM_W-1:0];
          CFG_MAX_DEV:    max_dev = cfg_wdata[DEV_W-1:0];
          CFG_COVER:      cover_frac = cfg_wdata[COVER_W-1:0];
          default: ;
        endcase
      end
    end
    pending = verdict_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the ROI motion detector testbench: clock, reset, register set-up,
// pixel stimulus and result back-pressure; verdict from rmd_verdict_checker.
// Depends on rmd_pkg, rmd_pix_if, rmd_res_if and roi_motion_detector.
module tb_top;
  import rmd_pkg::*;

  localparam int MAX_DIM       = 4096;
  localparam int PHASES        = 24;
  localparam int PHASE_ITEMS   = 42;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;

  typedef enum int {PACE_FULL, PACE_RANDOM, PACE_BURSTY} pace_t;
  typedef enum int {FILL_CLEAR, FILL_SET, FILL_ANY, FILL_BINARY} fill_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    pending;
  int                    stall_cycles;
  int                    items_sent;
  pace_t                 tx_pace;
  int cur_x, cur_y, cur_w, cur_h, cur_dev, cur_cover;

  rmd_pix_if pix_ch();
  rmd_res_if res_ch();

  roi_motion_detector #(.MAX_DIM(MAX_DIM)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rmd_verdict_checker #(.MAX_DIM(MAX_DIM)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix        (pix_ch),
    .res        (res_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int draw_gap(input pace_t pace);
    case (pace)
      PACE_FULL:   return 0;
      PACE_RANDOM: return $urandom_range(0, 15);
      default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_value(input fill_t fill, input int density);
    case (fill)
      FILL_CLEAR: return '0;
      FILL_SET:   return PIX_CHANGED;
      FILL_ANY:   return PIX_W'($urandom_range(0, 255));
      default:    return ($urandom_range(0, 99) < density) ? PIX_CHANGED : '0;
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] v, input int x, input int y,
                            input bit is_last);
    int gap;
    gap = draw_gap(tx_pace);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel_value <= v;
    pix_ch.pixel_x     <= COORD_W'(x);
    pix_ch.pixel_y     <= COORD_W'(y);
    pix_ch.frame_last  <= is_last;
    do @(posedge clk); while (!pix_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(negedge clk);
  endtask

  task automatic set_roi(input int x, input int y, input int w, input int h,
                         input int dev, input int cov);
    cur_x = x; cur_y = y; cur_w = w; cur_h = h; cur_dev = dev; cur_cover = cov;
    write_reg(CFG_ROI_X, cur_x);
    write_reg(CFG_ROI_Y, cur_y);
    write_reg(CFG_ROI_WIDTH, cur_w);
    write_reg(CFG_ROI_HEIGHT, cur_h);
    write_reg(CFG_MAX_DEV, cur_dev);
    write_reg(CFG_COVER, cur_cover);
    cfg_we <= 1'b0;
  endtask

  // block idle: nothing owed, evaluator finished
  task automatic settle();
    pix_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 4095;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return MAX_DIM;
      2:       return $urandom_range(MAX_DIM + 1, 8191);
      default: return $urandom_range(1, 10);
    endcase
  endfunction

  task automatic pick_settings(input int p);
    int dev, cov;
    case (p)
      0: set_roi(4095, 4095, 8191, 1, 255, 511);
      1: set_roi(0, 0, 1, MAX_DIM, 0, 0);
      default: begin
        case ($urandom_range(0, 3))
          0:       dev = 0;
          1:       dev = 255;
          default: dev = $urandom_range(0, 255);
        endcase
        case ($urandom_range(0, 4))
          0:       cov = 0;
          1:       cov = 256;
          2:       cov = $urandom_range(257, 511);
          default: cov = $urandom_range(0, 256);
        endcase
        set_roi(pick_coord(), pick_coord(), pick_dim(), pick_dim(), dev, cov);
      end
    endcase
  endtask

  task automatic send_noise();
    send_pixel(PIX_W'($urandom), $urandom_range(0, 4095), $urandom_range(0, 4095),
               $urandom_range(0, 29) == 0);
  endtask

  // raster-scanned window around the rectangle; broken frames skip, repeat
  // or end early
  task automatic send_frame();
    int    fw, fh, ox, oy, ew, eh, n, stop_at, density, reps, k, r;
    bit    broken, is_last;
    fill_t fill;
    ew = (cur_w > MAX_DIM) ? MAX_DIM : cur_w;
    eh = (cur_h > MAX_DIM) ? MAX_DIM : cur_h;
    fw = ((ew < 6) ? ew : 6) + $urandom_range(0, 2);
    fh = ((eh < 5) ? eh : 5) + $urandom_range(0, 2);
    if (fw < 1) fw = 1;
    if (fh < 1) fh = 1;
    ox = cur_x - $urandom_range(0, 2);
    oy = cur_y - $urandom_range(0, 2);
    if (ox < 0) ox = 0;
    if (oy < 0) oy = 0;
    if (ox > 4096 - fw) ox = 4096 - fw;
    if (oy > 4096 - fh) oy = 4096 - fh;
    case ($urandom_range(0, 9))
      0:       fill = FILL_CLEAR;
      1:       fill = FILL_SET;
      2, 3:    fill = FILL_ANY;
      default: fill = FILL_BINARY;
    endcase
    density = $urandom_range(0, 100);
    broken  = ($urandom_range(0, 6) == 0);
    n = fw * fh;
    stop_at = n - 1;
    if (broken && $urandom_range(0, 2) == 0)
      stop_at = $urandom_range(0, n - 1);
    for (k = 0; k <= stop_at; k++) begin
      is_last = (k == stop_at);
      if (broken && !is_last && $urandom_range(0, 6) == 0)
        continue;
      reps = (broken && $urandom_range(0, 6) == 0) ? 2 : 1;
      for (r = 0; r < reps; r++)
        send_pixel(pick_value(fill, density), ox + k % fw, oy + k / fw,
                   is_last && (r == reps - 1));
    end
  endtask

  initial begin : result_sink
    int    gap, taken;
    pace_t pace;
    res_ch.ready = 1'b0;
    taken = 0;
    pace  = PACE_RANDOM;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (taken % 40 == 0)
        pace = pace_t'($urandom_range(0, 2));
      gap = (taken == 10 || taken == 45) ? HOLD_CYCLES : draw_gap(pace);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      taken++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (pix_ch.valid && pix_ch.ready) ||
        (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int p, target;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ROI_X;
    cfg_wdata = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel_value = '0;
    pix_ch.pixel_x = '0;
    pix_ch.pixel_y = '0;
    pix_ch.frame_last = 1'b0;
    items_sent = 0;
    tx_pace = PACE_RANDOM;
    cur_x = 0; cur_y = 0; cur_w = 64; cur_h = 64; cur_dev = 100; cur_cover = 64;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: corners, just outside, far corner
    send_pixel(PIX_CHANGED, 0, 0, 1'b0);
    send_pixel(PIX_CHANGED, 63, 63, 1'b0);
    send_pixel(PIX_CHANGED, 64, 0, 1'b0);
    send_pixel(PIX_CHANGED, 0, 64, 1'b0);
    send_pixel(8'd1, 63, 0, 1'b0);
    send_pixel(8'd128, 0, 63, 1'b1);
    send_pixel('0, 4095, 4095, 1'b1);
    settle();

    // tiny rectangle at the far corner, no deviation allowed
    set_roi(4094, 4094, 2, 2, 0, 0);
    send_pixel(PIX_CHANGED, 4094, 4094, 1'b0);
    send_pixel('0, 4095, 4094, 1'b0);
    send_pixel('0, 4094, 4095, 1'b0);
    send_pixel('0, 4095, 4095, 1'b1);
    send_pixel(PIX_CHANGED, 4094, 4094, 1'b0);
    send_pixel(PIX_CHANGED, 4095, 4094, 1'b0);
    send_pixel(PIX_CHANGED, 4094, 4095, 1'b0);
    send_pixel(PIX_CHANGED, 4095, 4095, 1'b1);
    settle();

    // empty rectangle, then oversized one with repeated pixels
    set_roi(4094, 4094, 0, 2, 255, 511);
    send_pixel(PIX_CHANGED, 4094, 4094, 1'b1);
    settle();
    set_roi(0, 0, 8191, 8191, 255, 256);
    send_pixel(PIX_CHANGED, 4095, 4095, 1'b0);
    send_pixel(PIX_CHANGED, 0, 0, 1'b1);
    send_pixel(PIX_CHANGED, 0, 0, 1'b0);
    send_pixel(PIX_CHANGED, 0, 0, 1'b0);
    send_pixel(PIX_CHANGED, 0, 0, 1'b1);

    for (p = 0; p < PHASES; p++) begin
      settle();
      pick_settings(p);
      tx_pace = pace_t'($urandom_range(0, 2));
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 4) == 0)
          send_noise();
        send_frame();
      end
    end
    settle();

    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
